@@ hw/rtl/slr_pkg.sv @@
// Shared types and constants for the slice rotate nearest-neighbour unit.
package slr_pkg;

  localparam int N_W    = 9;   // edge length register width
  localparam int COEF_W = 16;  // Q1.14 cosine and sine
  localparam int POS_W  = 8;   // row and column fields
  localparam int VOX_W  = 16;  // voxel fields on the ports
  localparam int DX_W   = 11;  // doubled offset 2*row - n
  localparam int PROD_W = DX_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FRAC_W = 15;  // numerators are in units of 2^-15
  localparam int Q_W    = SUM_W - FRAC_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN        = 2'd2;

  localparam logic [N_W-1:0]    SLICE_SIZE_RST = 9'd256;
  localparam logic [COEF_W-1:0] COS_RST        = 16'sd16384;
  localparam logic [COEF_W-1:0] SIN_RST        = 16'sd0;

  // Control of the word at the address stage, passed to the store.
  typedef struct packed {
    logic valid;
    logic rd;
    logic wr_ok;
    logic in_slice;
  } slr_ctl_t;

endpackage

@@ hw/rtl/slr_coord.sv @@
// Input register, rotation multipliers and source address stage.
module slr_coord #(
  parameter int MAX_EDGE = 256,
  parameter int AW       = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [slr_pkg::POS_W-1:0]         row,
  input  logic [slr_pkg::POS_W-1:0]         col,
  input  logic [slr_pkg::VOX_W-1:0]         voxel_in,
  input  logic [slr_pkg::N_W-1:0]           n,
  input  logic signed [slr_pkg::COEF_W-1:0] cos_q14,
  input  logic signed [slr_pkg::COEF_W-1:0] sin_q14,
  input  logic                              out_free,
  output slr_pkg::slr_ctl_t                 ctl,
  output logic [AW-1:0]                     addr,
  output logic [slr_pkg::VOX_W-1:0]         wdata
);
  import slr_pkg::*;

  localparam int IW = $clog2(MAX_EDGE);

  // stage 1: input register
  logic             v1, rd1;
  logic [POS_W-1:0] row1, col1;
  logic [VOX_W-1:0] vox1;

  // stage 2: products
  logic                     v2, rd2, wr_ok2;
  logic [AW-1:0]            waddr2;
  logic [VOX_W-1:0]         vox2;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;

  // stage 3: address
  logic v3, rd3, wr_ok3, in_slice3;

  logic ld1, ld2, ld3, leave3;

  logic signed [DX_W-1:0]   dx2, dy2;
  logic signed [PROD_W-1:0] p_xc_next, p_ys_next, p_xs_next, p_yc_next;
  logic signed [SUM_W-1:0]  x_num, y_num, centre;
  logic signed [Q_W-1:0]    x_q, y_q;
  logic                     in_slice_next;
  logic [AW-1:0]            raddr;

  assign leave3   = v3 && (!rd3 || out_free);
  assign ld3      = v2 && (!v3 || leave3);
  assign ld2      = v1 && (!v2 || ld3);
  assign in_ready = !v1 || ld2;
  assign ld1      = in_valid && in_ready;

  assign dx2 = $signed({2'b00, row1, 1'b0}) - $signed({2'b00, n});
  assign dy2 = $signed({2'b00, col1, 1'b0}) - $signed({2'b00, n});

  assign p_xc_next = dx2 * cos_q14;
  assign p_ys_next = dy2 * sin_q14;
  assign p_xs_next = dx2 * sin_q14;
  assign p_yc_next = dy2 * cos_q14;

  assign centre = $signed({{(SUM_W - N_W - 14){1'b0}}, n, 14'b0});
  assign x_num  = p_xc + p_ys + centre;
  assign y_num  = p_yc - p_xs + centre;

  // truncate toward zero: floor, then step up for negative values with a fraction
  assign x_q = Q_W'(x_num >>> FRAC_W) + Q_W'(x_num[SUM_W-1] && (|x_num[FRAC_W-1:0]));
  assign y_q = Q_W'(y_num >>> FRAC_W) + Q_W'(y_num[SUM_W-1] && (|y_num[FRAC_W-1:0]));

  assign in_slice_next = !x_q[Q_W-1] && !y_q[Q_W-1] &&
                         (x_q[Q_W-2:0] < (Q_W-1)'(n)) && (y_q[Q_W-2:0] < (Q_W-1)'(n));

  assign raddr = AW'(x_q[IW-1:0]) * AW'(MAX_EDGE) + AW'(y_q[IW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= 1'b1;
      end else if (ld2) begin
        v1 <= 1'b0;
      end
      if (ld2) begin
        v2 <= 1'b1;
      end else if (ld3) begin
        v2 <= 1'b0;
      end
      if (ld3) begin
        v3 <= 1'b1;
      end else if (leave3) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      rd1  <= mode;
      row1 <= row;
      col1 <= col;
      vox1 <= voxel_in;
    end
    if (ld2) begin
      rd2    <= rd1;
      vox2   <= vox1;
      wr_ok2 <= (32'(row1) < MAX_EDGE) && (32'(col1) < MAX_EDGE);
      waddr2 <= AW'(row1) * AW'(MAX_EDGE) + AW'(col1);
      p_xc   <= p_xc_next;
      p_ys   <= p_ys_next;
      p_xs   <= p_xs_next;
      p_yc   <= p_yc_next;
    end
    if (ld3) begin
      rd3       <= rd2;
      wr_ok3    <= wr_ok2;
      in_slice3 <= in_slice_next;
      addr      <= rd2 ? raddr : waddr2;
      wdata     <= vox2;
    end
  end

  assign ctl = '{valid: v3, rd: rd3, wr_ok: wr_ok3, in_slice: in_slice3};

endmodule

@@ hw/rtl/slr_store.sv @@
// Slice memory with registered read and the result register.
module slr_store #(
  parameter int MAX_EDGE   = 256,
  parameter int VOXEL_BITS = 16,
  parameter int AW         = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  slr_pkg::slr_ctl_t         ctl,
  input  logic [AW-1:0]             addr,
  input  logic [slr_pkg::VOX_W-1:0] wdata,
  output logic                      out_free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [slr_pkg::VOX_W-1:0] voxel_out,
  output logic                      inside_res
);
  import slr_pkg::*;

  localparam int DEPTH = MAX_EDGE * MAX_EDGE;

  logic [VOXEL_BITS-1:0] mem [DEPTH];
  logic [VOXEL_BITS-1:0] rdata;
  logic                  in_slice4;
  logic                  wr_en, rd_take;

  assign out_free = !out_valid || out_ready;
  assign wr_en    = ctl.valid && !ctl.rd && ctl.wr_ok;
  assign rd_take  = ctl.valid && ctl.rd && out_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= VOXEL_BITS'(wdata);
    end
    // hold the read word while the result stalls
    if (rd_take) begin
      rdata     <= mem[addr];
      in_slice4 <= ctl.in_slice;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign voxel_out  = in_slice4 ? VOX_W'(rdata) : '0;
  assign inside_res = in_slice4;

endmodule

@@ hw/rtl/slice_rotate_nearest_unit.sv @@
// Slice rotate nearest-neighbour unit: top level with configuration registers.
// A read word's result passes the input register, multiplier stage, address stage
// and the memory read into the result register. Throughput: one word per cycle while
// no read waits on a stalled result, set by the single memory port shared by writes
// and reads. Writes give no result. Reset clears the pipeline valids and loads the
// configuration reset values; the slice memory is not cleared.
module slice_rotate_nearest_unit #(
  parameter int MAX_EDGE   = 256,
  parameter int VOXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [slr_pkg::POS_W-1:0]           row,
  input  logic [slr_pkg::POS_W-1:0]           col,
  input  logic [slr_pkg::VOX_W-1:0]           voxel_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slr_pkg::VOX_W-1:0]           voxel_out,
  output logic                                inside_res,
  input  logic                                cfg_we,
  input  logic [slr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [slr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import slr_pkg::*;

  localparam int AW = $clog2(MAX_EDGE * MAX_EDGE);

  logic [N_W-1:0]           slice_size;
  logic signed [COEF_W-1:0] cos_q14, sin_q14;
  logic [N_W-1:0]           n_eff;
  slr_ctl_t                 ctl;
  logic [AW-1:0]            addr;
  logic [VOX_W-1:0]         wdata;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_size <= SLICE_SIZE_RST;
      cos_q14    <= COS_RST;
      sin_q14    <= SIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SLICE_SIZE: slice_size <= cfg_data[N_W-1:0];
        REG_COS:        cos_q14    <= cfg_data;
        REG_SIN:        sin_q14    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the edge to the store size
  assign n_eff = (32'(slice_size) > MAX_EDGE) ? N_W'(MAX_EDGE) : slice_size;

  slr_coord #(
    .MAX_EDGE (MAX_EDGE),
    .AW       (AW)
  ) u_coord (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .row      (row),
    .col      (col),
    .voxel_in (voxel_in),
    .n        (n_eff),
    .cos_q14  (cos_q14),
    .sin_q14  (sin_q14),
    .out_free (out_free),
    .ctl      (ctl),
    .addr     (addr),
    .wdata    (wdata)
  );

  slr_store #(
    .MAX_EDGE   (MAX_EDGE),
    .VOXEL_BITS (VOXEL_BITS),
    .AW         (AW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .addr       (addr),
    .wdata      (wdata),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .voxel_out  (voxel_out),
    .inside_res (inside_res)
  );

endmodule
